@@ sv/hrlc_pkg.sv @@
// shared types, constants and helper functions of the http request line checker
package hrlc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 12;

  localparam logic [CountW-1:0] UriLimitRst = 12'd1024;
  localparam logic [CountW-1:0] CountMax    = 12'hFFF;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChNul   = 8'h00;

  typedef enum logic [3:0] {
    PH_M_SKIP  = 4'd0,
    PH_M_TOK   = 4'd1,
    PH_U_SKIP  = 4'd2,
    PH_U_TOK   = 4'd3,
    PH_V_CRLF  = 4'd4,
    PH_V_SP    = 4'd5,
    PH_V_MATCH = 4'd6,
    PH_V_TAIL  = 4'd7,
    PH_FIN     = 4'd8
  } hrlc_phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_VER   = 2'd2,
    ST_EMPTY = 2'd3
  } hrlc_status_e;

  // one result item as it leaves the parser
  typedef struct packed {
    logic               produce;
    logic               uri_valid;
    logic [CharW-1:0]   uri_byte;
    logic               done_res;
    hrlc_status_e       status;
    logic               head_sel;
    logic [CountW-1:0]  uri_length;
  } hrlc_res_t;

  function automatic logic [CharW-1:0] get_char(input logic [1:0] idx);
    unique case (idx)
      2'd0:    get_char = 8'h47; // G
      2'd1:    get_char = 8'h45; // E
      2'd2:    get_char = 8'h54; // T
      default: get_char = 8'h00;
    endcase
  endfunction

  function automatic logic [CharW-1:0] head_char(input logic [1:0] idx);
    unique case (idx)
      2'd0:    head_char = 8'h48; // H
      2'd1:    head_char = 8'h45; // E
      2'd2:    head_char = 8'h41; // A
      default: head_char = 8'h44; // D
    endcase
  endfunction

  function automatic logic [CharW-1:0] ver_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    ver_char = 8'h48; // H
      3'd1:    ver_char = 8'h54; // T
      3'd2:    ver_char = 8'h54; // T
      3'd3:    ver_char = 8'h50; // P
      3'd4:    ver_char = 8'h2F; // /
      3'd5:    ver_char = 8'h31; // 1
      3'd6:    ver_char = 8'h2E; // .
      default: ver_char = 8'h30; // 0
    endcase
  endfunction

  // status reported if the request ended in the given phase
  function automatic hrlc_status_e end_status(input hrlc_phase_e  ph,
                                              input logic         over,
                                              input hrlc_status_e err);
    unique case (ph)
      PH_M_SKIP:  end_status = ST_EMPTY;
      PH_M_TOK:   end_status = ST_BAD;
      PH_U_SKIP:  end_status = ST_BAD;
      PH_U_TOK:   end_status = over ? ST_BAD : ST_VER;
      PH_V_CRLF:  end_status = ST_VER;
      PH_V_SP:    end_status = ST_VER;
      PH_V_MATCH: end_status = ST_VER;
      PH_V_TAIL:  end_status = ST_OK;
      default:    end_status = err;
    endcase
  endfunction

endpackage

@@ sv/hrlc_if.sv @@
// byte input and result output channel interfaces
interface hrlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface hrlc_out_if;
  logic        valid;
  logic        ready;
  logic        uri_valid;
  logic [7:0]  uri_byte;
  logic        done_res;
  logic [1:0]  status;
  logic        head_sel;
  logic [11:0] uri_length;

  modport source (output valid, output uri_valid, output uri_byte, output done_res,
                  output status, output head_sel, output uri_length, input ready);
  modport sink   (input valid, input uri_valid, input uri_byte, input done_res,
                  input status, input head_sel, input uri_length, output ready);
endinterface

@@ sv/hrlc_cfg.sv @@
// uri length limit configuration register
module hrlc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hrlc_pkg::CountW-1:0] cfg_wdata_i,
  output logic [hrlc_pkg::CountW-1:0] uri_limit_o
);
  import hrlc_pkg::*;

  logic [CountW-1:0] uri_limit_q, uri_limit_d;

  assign uri_limit_d = cfg_we_i ? cfg_wdata_i : uri_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uri_limit_q <= UriLimitRst;
    end else begin
      uri_limit_q <= uri_limit_d;
    end
  end

  assign uri_limit_o = uri_limit_q;
endmodule

@@ sv/hrlc_parser.sv @@
// request line state machine: one byte per step, builds the result item
module hrlc_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        commit_i,
  input  logic [hrlc_pkg::CharW-1:0]  ch_i,
  input  logic                        last_i,
  input  logic [hrlc_pkg::CountW-1:0] uri_limit_i,
  output hrlc_pkg::hrlc_res_t         res_o
);
  import hrlc_pkg::*;

  hrlc_phase_e       phase_q, phase_d, phase_s;
  logic [3:0]        idx_q, idx_d, idx_s;
  logic [1:0]        flags_q, flags_d, flags_s;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_s;
  hrlc_status_e      err_q, err_d, err_s;
  logic              head_q, head_d, head_s;
  logic              over_q, over_d, over_s;
  logic              uv;
  logic              is_crlf;

  assign is_crlf = (ch_i == ChCr) || (ch_i == ChLf);

  // one step of the parser on the byte held in the input register
  always_comb begin
    phase_s = phase_q;
    idx_s   = idx_q;
    flags_s = flags_q;
    cnt_s   = cnt_q;
    err_s   = err_q;
    head_s  = head_q;
    over_s  = over_q;
    uv      = 1'b0;

    if (phase_q != PH_FIN && ch_i == ChNul) begin
      // zero byte ends the request text
      err_s   = end_status(phase_q, over_q, err_q);
      phase_s = PH_FIN;
    end else begin
      unique case (phase_q)
        PH_M_SKIP, PH_M_TOK: begin
          if (ch_i == ChSpace) begin
            if (phase_q == PH_M_TOK) begin
              if (flags_q[0] && idx_q == 4'd3) begin
                head_s  = 1'b0;
                phase_s = PH_U_SKIP;
              end else if (flags_q[1] && idx_q == 4'd4) begin
                head_s  = 1'b1;
                phase_s = PH_U_SKIP;
              end else begin
                err_s   = ST_BAD;
                phase_s = PH_FIN;
              end
              idx_s = 4'd0;
            end
          end else begin
            phase_s = PH_M_TOK;
            if (idx_q >= 4'd3 || ch_i != get_char(idx_q[1:0])) begin
              flags_s[0] = 1'b0;
            end
            if (idx_q >= 4'd4 || ch_i != head_char(idx_q[1:0])) begin
              flags_s[1] = 1'b0;
            end
            if (idx_q != 4'd15) begin
              idx_s = idx_q + 4'd1;
            end
          end
        end
        PH_U_SKIP, PH_U_TOK: begin
          if (ch_i == ChSpace) begin
            if (phase_q == PH_U_TOK) begin
              if (over_q) begin
                err_s   = ST_BAD;
                phase_s = PH_FIN;
              end else begin
                phase_s = PH_V_CRLF;
              end
            end
          end else begin
            phase_s = PH_U_TOK;
            if (cnt_q >= uri_limit_i) begin
              over_s = 1'b1;
            end
            if (cnt_q != CountMax) begin
              cnt_s = cnt_q + CountW'(1);
            end
            uv = 1'b1;
          end
        end
        PH_V_CRLF, PH_V_SP, PH_V_MATCH: begin
          if (phase_q == PH_V_CRLF && ch_i == ChSpace) begin
            phase_s = PH_V_SP;
          end else if (is_crlf) begin
            if (phase_q != PH_V_CRLF) begin
              err_s   = ST_VER;
              phase_s = PH_FIN;
            end
          end else if (phase_q == PH_V_SP && ch_i == ChSpace) begin
            phase_s = PH_V_SP;
          end else if (idx_q < 4'd8 && ch_i == ver_char(idx_q[2:0])) begin
            idx_s   = idx_q + 4'd1;
            phase_s = (idx_q == 4'd7) ? PH_V_TAIL : PH_V_MATCH;
          end else begin
            err_s   = ST_VER;
            phase_s = PH_FIN;
          end
        end
        PH_V_TAIL: begin
          if (is_crlf) begin
            err_s   = ST_OK;
            phase_s = PH_FIN;
          end else if (ch_i != ChSpace) begin
            err_s   = ST_VER;
            phase_s = PH_FIN;
          end
        end
        default: ;
      endcase
    end
  end

  // the last byte closes the request and clears for the next one
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    flags_d = flags_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    head_d  = head_q;
    over_d  = over_q;
    if (commit_i) begin
      if (last_i) begin
        phase_d = PH_M_SKIP;
        idx_d   = 4'd0;
        flags_d = 2'b11;
        cnt_d   = '0;
        err_d   = ST_OK;
        head_d  = 1'b0;
        over_d  = 1'b0;
      end else begin
        phase_d = phase_s;
        idx_d   = idx_s;
        flags_d = flags_s;
        cnt_d   = cnt_s;
        err_d   = err_s;
        head_d  = head_s;
        over_d  = over_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_M_SKIP;
      idx_q   <= 4'd0;
      flags_q <= 2'b11;
      cnt_q   <= '0;
      err_q   <= ST_OK;
      head_q  <= 1'b0;
      over_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      flags_q <= flags_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      head_q  <= head_d;
      over_q  <= over_d;
    end
  end

  always_comb begin
    res_o.produce     = uv || last_i;
    res_o.uri_valid   = uv;
    res_o.uri_byte    = uv ? ch_i : '0;
    res_o.done_res    = last_i;
    res_o.status      = last_i ? end_status(phase_s, over_s, err_s) : ST_OK;
    res_o.head_sel    = last_i ? head_s : 1'b0;
    res_o.uri_length  = last_i ? cnt_s : '0;
  end
endmodule

@@ sv/http_request_line_checker.sv @@
// http request line checker: one byte per cycle unless the output stalls, registered results
// path: a byte is held in the input register and parsed there, and its result is
//   loaded into the output register, from which it is offered to the receiver
// throughput: one byte per cycle; the input register stalls only when a byte
//   with a result meets a full, unaccepted output register
// reset: parser state returns to the method space skip, uri limit to 1024,
//   both register stages empty
module http_request_line_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hrlc_pkg::CountW-1:0] cfg_wdata_i,
  hrlc_in_if.sink                     req_i,
  hrlc_out_if.source                  res_o
);
  import hrlc_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [CharW-1:0]  s1_ch_q;
  logic              s1_last_q;
  logic              s1_adv;
  logic              out_free;
  logic              in_xfer;
  logic [CountW-1:0] uri_limit;
  hrlc_res_t         res;

  logic              out_valid_q, out_valid_d;
  hrlc_res_t         out_q;

  hrlc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .uri_limit_o (uri_limit)
  );

  hrlc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (s1_adv),
    .ch_i        (s1_ch_q),
    .last_i      (s1_last_q),
    .uri_limit_i (uri_limit),
    .res_o       (res)
  );

  assign out_free    = !out_valid_q || res_o.ready;
  // a byte without a result never waits on the output side
  assign s1_adv      = s1_valid_q && (!res.produce || out_free);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer     = req_i.valid && req_i.ready;
  assign s1_valid_d  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && res.produce) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q   <= req_i.ch;
      s1_last_q <= req_i.last;
    end
    if (s1_adv && res.produce) begin
      out_q <= res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.uri_valid   = out_q.uri_valid;
  assign res_o.uri_byte    = out_q.uri_byte;
  assign res_o.done_res    = out_q.done_res;
  assign res_o.status      = out_q.status;
  assign res_o.head_sel    = out_q.head_sel;
  assign res_o.uri_length  = out_q.uri_length;
endmodule

@@ dv/hrlc_line_monitor.sv @@
// request line parser model and result transfer comparison for the testbench
`timescale 1ns / 1ps
module hrlc_line_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hrlc_pkg::CountW-1:0] cfg_wdata_i,
  hrlc_in_if                          req_i,
  hrlc_out_if                         res_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o,
  output int unsigned                 lines_o,
  output int unsigned                 uri_bytes_o,
  output logic [3:0]                  status_seen_o
);
  import hrlc_pkg::*;

  localparam logic [23:0] WordGet  = "GET";
  localparam logic [31:0] WordHead = "HEAD";
  localparam logic [63:0] WordVer  = "HTTP/1.0";

  typedef struct packed {
    logic              uri_valid;
    logic [CharW-1:0]  uri_byte;
    logic              done_res;
    hrlc_status_e      status;
    logic              head_sel;
    logic [CountW-1:0] uri_length;
  } line_res_t;

  hrlc_phase_e       ph;
  logic [3:0]        idx;
  logic [1:0]        mflags;  // bit 0: GET still possible, bit 1: HEAD
  logic [CountW-1:0] ucount;
  hrlc_status_e      err;
  logic              is_head;
  logic              over;    // sticky, uri went past the limit
  logic [CountW-1:0] limit;

  line_res_t   line_results_q[$];
  int unsigned errs;
  int unsigned lines;
  int unsigned uri_bytes;
  logic [3:0]  seen;

  function automatic void clear_line();
    ph      = PH_M_SKIP;
    idx     = '0;
    mflags  = 2'b11;
    ucount  = '0;
    err     = ST_OK;
    is_head = 1'b0;
    over    = 1'b0;
  endfunction

  function automatic void close_line(input hrlc_status_e st);
    err = st;
    ph  = PH_FIN;
  endfunction

  function automatic hrlc_status_e line_status();
    case (ph)
      PH_M_SKIP:                      return ST_EMPTY;
      PH_M_TOK, PH_U_SKIP:            return ST_BAD;
      PH_U_TOK:                       return over ? ST_BAD : ST_VER;
      PH_V_CRLF, PH_V_SP, PH_V_MATCH: return ST_VER;
      PH_V_TAIL:                      return ST_OK;
      default:                        return err;
    endcase
  endfunction

  function automatic void method_byte(input logic [CharW-1:0] c);
    int k;
    k = int'(idx);
    if (k >= 3) mflags[0] = 1'b0;
    else if (c != WordGet[8*(2-k) +: 8]) mflags[0] = 1'b0;
    if (k >= 4) mflags[1] = 1'b0;
    else if (c != WordHead[8*(3-k) +: 8]) mflags[1] = 1'b0;
    if (idx != 4'd15) idx++;
  endfunction

  function automatic void method_end();
    if (mflags[0] && idx == 4'd3) begin
      is_head = 1'b0;
      ph      = PH_U_SKIP;
    end else if (mflags[1] && idx == 4'd4) begin
      is_head = 1'b1;
      ph      = PH_U_SKIP;
    end else begin
      close_line(ST_BAD);
    end
    idx = '0;
  endfunction

  function automatic void version_byte(input logic [CharW-1:0] c);
    int k;
    k = int'(idx);
    if (k >= 8) begin
      close_line(ST_VER);
    end else if (c == WordVer[8*(7-k) +: 8]) begin
      idx++;
      ph = (idx == 4'd8) ? PH_V_TAIL : PH_V_MATCH;
    end else begin
      close_line(ST_VER);
    end
  endfunction

  // advances the parser by one byte, returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [CharW-1:0] c, input logic lst,
                                    output line_res_t r);
    logic crlf;
    crlf = (c == ChCr) || (c == ChLf);
    r = '0;
    if (ph != PH_FIN && c == ChNul) begin
      close_line(line_status());
    end else begin
      case (ph)
        PH_M_SKIP: begin
          if (c != ChSpace) begin
            ph = PH_M_TOK;
            method_byte(c);
          end
        end
        PH_M_TOK: begin
          if (c == ChSpace) method_end();
          else method_byte(c);
        end
        PH_U_SKIP, PH_U_TOK: begin
          if (c == ChSpace) begin
            if (ph == PH_U_TOK) begin
              if (over) close_line(ST_BAD);
              else ph = PH_V_CRLF;
            end
          end else begin
            ph = PH_U_TOK;
            if (ucount >= limit) over = 1'b1;
            if (ucount != CountMax) ucount++;
            r.uri_valid = 1'b1;
            r.uri_byte  = c;
          end
        end
        PH_V_CRLF: begin
          if (c == ChSpace) ph = PH_V_SP;
          else if (!crlf) version_byte(c);
        end
        PH_V_SP: begin
          if (crlf) close_line(ST_VER);
          else if (c != ChSpace) version_byte(c);
        end
        PH_V_MATCH: begin
          if (crlf) close_line(ST_VER);
          else version_byte(c);
        end
        PH_V_TAIL: begin
          if (crlf) close_line(ST_OK);
          else if (c != ChSpace) close_line(ST_VER);
        end
        default: ;
      endcase
    end
    if (lst) begin
      r.done_res    = 1'b1;
      r.status      = line_status();
      r.head_sel    = is_head;
      r.uri_length  = ucount;
      clear_line();
    end
    return lst || r.uri_valid;
  endfunction

  function automatic void flag_field(input string name, input logic [CountW-1:0] want,
                                     input logic [CountW-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    errs++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_res_t want;
    line_res_t got;
    if (!rst_ni) begin
      clear_line();
      limit = UriLimitRst;
      line_results_q.delete();
      errs      = 0;
      lines     = 0;
      uri_bytes = 0;
      seen      = '0;
    end else begin
      if (cfg_we_i) limit = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        if (parse_byte(req_i.ch, req_i.last, want)) line_results_q.push_back(want);
      end
      if (res_i.valid && res_i.ready) begin
        got.uri_valid   = res_i.uri_valid;
        got.uri_byte    = res_i.uri_byte;
        got.done_res    = res_i.done_res;
        got.status      = hrlc_status_e'(res_i.status);
        got.head_sel    = res_i.head_sel;
        got.uri_length  = res_i.uri_length;
        if (line_results_q.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding, expected none, actual %h",
                   $time, got);
          errs++;
        end else begin
          want = line_results_q.pop_front();
          if (got.uri_valid !== want.uri_valid)
            flag_field("uri_valid", CountW'(want.uri_valid), CountW'(got.uri_valid));
          if (got.uri_byte !== want.uri_byte)
            flag_field("uri_byte", CountW'(want.uri_byte), CountW'(got.uri_byte));
          if (got.done_res !== want.done_res)
            flag_field("done_res", CountW'(want.done_res), CountW'(got.done_res));
          if (got.status !== want.status)
            flag_field("status", CountW'(want.status), CountW'(got.status));
          if (got.head_sel !== want.head_sel)
            flag_field("head_sel", CountW'(want.head_sel), CountW'(got.head_sel));
          if (got.uri_length !== want.uri_length)
            flag_field("uri_length", want.uri_length, got.uri_length);
        end
        if (got.done_res === 1'b1) begin
          lines++;
          seen[res_i.status] = 1'b1;
        end
        if (got.uri_valid === 1'b1) uri_bytes++;
      end
    end
    errors_o      <= errs;
    pending_o     <= line_results_q.size();
    lines_o       <= lines;
    uri_bytes_o   <= uri_bytes;
    status_seen_o <= seen;
  end

endmodule

@@ dv/tb_http_request_line_checker.sv @@
// top of the request line checker testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_http_request_line_checker;
  import hrlc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseBytes = 100;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned lines_done;
  int unsigned uri_bytes_out;
  logic [3:0]  status_seen;

  int unsigned       cycles     = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       burst_left = 0;
  logic [CountW-1:0] cur_limit  = UriLimitRst;
  logic [CharW-1:0]  line_q[$];
  logic [7:0]        ready_pat  = 8'hFF;
  int unsigned       pat_age    = 0;
  logic [CountW-1:0] limit_plan [6];

  hrlc_in_if  req_if ();
  hrlc_out_if res_if ();

  http_request_line_checker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  hrlc_line_monitor u_mon (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .req_i         (req_if),
    .res_i         (res_if),
    .errors_o      (fail_count),
    .pending_o     (pending),
    .lines_o       (lines_done),
    .uri_bytes_o   (uri_bytes_out),
    .status_seen_o (status_seen)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls follow a rotating pattern that is swapped now and then
  always @(negedge clk) begin
    if (pat_age == 0) begin
      ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
      pat_age   = $urandom_range(16, 96);
    end
    pat_age--;
    res_if.ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[7:1]};
  end

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void push_spaces(input int unsigned n);
    repeat (n) line_q.push_back(ChSpace);
  endfunction

  function automatic void push_uri(input int unsigned n);
    logic [CharW-1:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(1, 255)); while (b == ChSpace);
      line_q.push_back(b);
    end
  endfunction

  function automatic void build_random_line();
    int unsigned pick;
    int unsigned lo;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_spaces($urandom_range(1, 4));
      return;
    end
    if (pick < 18) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) push_spaces($urandom_range(1, 3));
    if ($urandom_range(0, 1) == 0) push_text("GET");
    else push_text("HEAD");
    push_spaces($urandom_range(1, 3));
    // aim at the limit boundary now and then while the limit is small
    lo = (cur_limit > 1) ? int'(cur_limit) - 1 : 1;
    if (cur_limit <= 64 && $urandom_range(0, 3) == 0)
      push_uri($urandom_range(lo, int'(cur_limit) + 1));
    else
      push_uri($urandom_range(1, 16));
    line_q.push_back(ChSpace);
    if ($urandom_range(0, 3) == 0) push_text("\r\n");
    if ($urandom_range(0, 3) == 0) push_spaces($urandom_range(1, 2));
    push_text("HTTP/1.0");
    if ($urandom_range(0, 3) == 0) push_spaces($urandom_range(1, 2));
    case ($urandom_range(0, 3))
      0: ;
      1: push_text("\r\n");
      2: push_text("\r\nHost: h\r\n");
      default: push_text("\n");
    endcase
    if (pick >= 82) begin
      k = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 2))
        0: line_q[k] = ChNul;
        1: line_q[k] = 8'($urandom_range(0, 255));
        default: line_q = line_q[0:k];
      endcase
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [CharW-1:0] c, input logic lst);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 10);
    end
    req_if.valid <= 1'b1;
    req_if.ch    <= c;
    req_if.last  <= lst;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
    bytes_sent += line_q.size();
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_line();
  endtask

  // the last byte of a line always yields a result, so no pending result means the line has drained
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CountW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
  endtask

  initial begin
    int unsigned phase_start;
    req_if.valid = 1'b0;
    req_if.ch    = '0;
    req_if.last  = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed lines under the reset limit
    send_text("GET / HTTP/1.0\r\n");
    send_text("HEAD /index.html HTTP/1.0");
    send_text("   ");
    line_q.push_back(ChNul);
    send_line();
    send_text("POST / HTTP/1.0\r\n");
    send_text("GETS / HTTP/1.0\r\n");
    send_text("HEA / HTTP/1.0\r\n");
    send_text("get / HTTP/1.0\r\n");
    send_text("  GET");
    send_text("HEAD   ");
    send_text("GET /abc");
    send_text("GET /abc \r\n");
    send_text("GET /abc   \r\nHTTP/1.0");
    send_text("GET /a HTTP/1.1\r\n");
    send_text("GET /a HTTP/1.0x\r\n");
    send_text("GET /a HTTP");
    send_text("GET /a HTTP/1.0   \r\nHost: x\r\n");
    send_text("GET /a\r\nb HTTP/1.0\r\n");
    send_text("GET /a \r\n  HTTP/1.0\r\n");
    push_text("GET /z");
    line_q.push_back(ChNul);
    send_text(" HTTP/1.0\r\n");
    push_text("HEAD ");
    line_q.push_back(ChNul);
    send_text("junk");
    push_text("GET /");
    line_q.push_back(8'hFF);
    line_q.push_back(8'h80);
    line_q.push_back(8'h7F);
    line_q.push_back(8'h01);
    send_text(" HTTP/1.0\r\n");

    // widest limit: a long uri well inside it
    wait_idle();
    write_limit(CountMax);
    push_text("GET ");
    push_uri(200);
    send_text(" HTTP/1.0\r\n");

    limit_plan = '{12'd1, 12'd0, CountMax, 12'd7, 12'($urandom_range(2, 64)), UriLimitRst};
    foreach (limit_plan[p]) begin
      wait_idle();
      write_limit(limit_plan[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        build_random_line();
        send_line();
      end
    end

    wait_idle();
    $display("run covered %0d request lines from %0d input bytes, %0d uri bytes compared",
             lines_done, bytes_sent, uri_bytes_out);
    $display("uri limits 1024, 4095, 1, 0, 7 and %0d; status codes seen %b (one bit per code)",
             limit_plan[4], status_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/hrlc_pkg.sv
sv/hrlc_if.sv
sv/hrlc_cfg.sv
sv/hrlc_parser.sv
sv/http_request_line_checker.sv
dv/hrlc_line_monitor.sv
dv/tb_http_request_line_checker.sv
